>>> src/i2cm_pkg.sv
// Shared types, codes and constants of the I2C master transaction engine.
package i2cm_pkg;

	localparam int PHASE_W = 16;
	localparam int REC_W = 5;
	localparam logic [REC_W-1:0] RECOVERY_LIMIT = 5'd20;

	localparam logic [1:0] CMD_TICK  = 2'd0;
	localparam logic [1:0] CMD_READ  = 2'd1;
	localparam logic [1:0] CMD_WRITE = 2'd2;

	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_BUS_BUSY  = 2'd1;
	localparam logic [1:0] ST_ADDR_NACK = 2'd2;
	localparam logic [1:0] ST_DATA_NACK = 2'd3;

	localparam logic [3:0] PH_IDLE     = 4'd0;
	localparam logic [3:0] PH_CHK      = 4'd1;
	localparam logic [3:0] PH_RCV_LOW  = 4'd2;
	localparam logic [3:0] PH_RCV_HIGH = 4'd3;
	localparam logic [3:0] PH_START    = 4'd4;
	localparam logic [3:0] PH_BIT_A    = 4'd5;
	localparam logic [3:0] PH_BIT_B    = 4'd6;
	localparam logic [3:0] PH_BIT_C    = 4'd7;
	localparam logic [3:0] PH_BIT_R    = 4'd8;
	localparam logic [3:0] PH_BIT_S    = 4'd9;
	localparam logic [3:0] PH_BIT_D    = 4'd10;
	localparam logic [3:0] PH_STOP_A   = 4'd11;
	localparam logic [3:0] PH_STOP_B   = 4'd12;
	localparam logic [3:0] PH_STOP_C   = 4'd13;
	localparam logic [3:0] PH_STOP_D   = 4'd14;

	typedef struct packed {
		logic [1:0] cmd;
		logic [6:0] address;
		logic [7:0] length;
		logic       send_stop;
		logic [7:0] tx_byte;
		logic       scl_in;
		logic       sda_in;
	} req_t;

	typedef struct packed {
		logic       scl_drive_low;
		logic       sda_drive_low;
		logic [7:0] rx_data;
		logic       rx_valid;
		logic       tx_taken;
		logic       busy_res;
		logic       done_res;
		logic [1:0] status;
		logic [7:0] byte_count;
	} res_t;

endpackage

>>> src/i2cm_req_if.sv
// Tick channel into the engine: one bus timing tick with command and line samples.
interface i2cm_req_if;
	logic       valid;
	logic       ready;
	logic [1:0] cmd;
	logic [6:0] address;
	logic [7:0] length;
	logic       send_stop;
	logic [7:0] tx_byte;
	logic       scl_in;
	logic       sda_in;

	modport source (output valid, cmd, address, length, send_stop, tx_byte, scl_in, sda_in,
		input ready);
	modport sink (input valid, cmd, address, length, send_stop, tx_byte, scl_in, sda_in,
		output ready);
endinterface

>>> src/i2cm_rsp_if.sv
// Result channel out of the engine: line drives and transaction status per tick.
interface i2cm_rsp_if;
	logic       valid;
	logic       ready;
	logic       scl_drive_low;
	logic       sda_drive_low;
	logic [7:0] rx_data;
	logic       rx_valid;
	logic       tx_taken;
	logic       busy_res;
	logic       done_res;
	logic [1:0] status;
	logic [7:0] byte_count;

	modport source (output valid, scl_drive_low, sda_drive_low, rx_data, rx_valid, tx_taken,
		busy_res, done_res, status, byte_count, input ready);
	modport sink (input valid, scl_drive_low, sda_drive_low, rx_data, rx_valid, tx_taken,
		busy_res, done_res, status, byte_count, output ready);
endinterface

>>> src/i2cm_cfg_if.sv
// Configuration write channel carrying the phase length register.
interface i2cm_cfg_if;
	logic        valid;
	logic        ready;
	logic [15:0] data;

	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface

>>> src/i2c_master_transaction_engine_core.sv
// Top level of the I2C master transaction engine: channels, tick pipeline and result register.
//
// Usage: each transaction on req is one tick of the bus timing base. It carries the
// command (tick, begin read, begin write), the address, length, stop option, the next
// write byte and the sampled SCL and SDA levels. Every accepted tick gives exactly one
// transaction on rsp with the open-drain drives, read data, tx_taken, busy, done,
// status and byte count. cfg writes the phase length (extra ticks per bit phase); write
// it only while no transaction is running on the bus and no tick is in flight.
// Each tick passes one input register and one result register around the sequencer logic.
// Throughput: one tick per cycle while rsp does not stall.
// When rsp stalls, both stages hold and req.ready drops in the same cycle; no tick is
// lost or repeated. Reset clears the pipeline, releases both lines, sets the sequencer
// to idle and the phase length to zero. cfg is always ready.
module i2c_master_transaction_engine_core (
	input logic clk,
	input logic arst_n,
	i2cm_cfg_if.sink cfg,
	i2cm_req_if.sink req,
	i2cm_rsp_if.source rsp
);
	import i2cm_pkg::*;

	logic [PHASE_W-1:0] lim_q;
	req_t               req_s1;
	logic               vld_s1;
	res_t               res_s2;
	logic               vld_s2;
	res_t               res_c;
	logic               adv;

	assign adv = !vld_s2 || rsp.ready;
	assign req.ready = adv;
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			lim_q <= '0;
		else if (cfg.valid)
			lim_q <= cfg.data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= req.valid;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			req_s1 <= '{cmd: req.cmd, address: req.address, length: req.length,
				send_stop: req.send_stop, tx_byte: req.tx_byte,
				scl_in: req.scl_in, sda_in: req.sda_in};
			res_s2 <= res_c;
		end
	end

	i2cm_engine u_engine (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (adv && vld_s1),
		.lim    (lim_q),
		.item   (req_s1),
		.res    (res_c)
	);

	assign rsp.valid         = vld_s2;
	assign rsp.scl_drive_low = res_s2.scl_drive_low;
	assign rsp.sda_drive_low = res_s2.sda_drive_low;
	assign rsp.rx_data       = res_s2.rx_data;
	assign rsp.rx_valid      = res_s2.rx_valid;
	assign rsp.tx_taken      = res_s2.tx_taken;
	assign rsp.busy_res      = res_s2.busy_res;
	assign rsp.done_res      = res_s2.done_res;
	assign rsp.status        = res_s2.status;
	assign rsp.byte_count    = res_s2.byte_count;

	a_done_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s2 && res_s2.done_res) |-> !res_s2.busy_res)
		else $error("done reported while still busy");
	a_tx_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s2 && res_s2.tx_taken) |-> res_s2.busy_res)
		else $error("write byte taken outside a transaction");
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s2 && !rsp.ready) |=> (vld_s2 && $stable(res_s2)))
		else $error("result changed while stalled");

endmodule

>>> src/i2cm_engine.sv
// Bus sequencer: state registers and the one-tick next-state and result logic.
module i2cm_engine (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	input  logic [i2cm_pkg::PHASE_W-1:0]  lim,
	input  i2cm_pkg::req_t                item,
	output i2cm_pkg::res_t                res
);
	import i2cm_pkg::*;

	logic [3:0]         phase_q, n_phase;
	logic [PHASE_W-1:0] tick_q, n_tick, tick_adv;
	logic [3:0]         bit_q, n_bit;
	logic [7:0]         byte_q, n_byte;
	logic [7:0]         shift_q, n_shift;
	logic [REC_W-1:0]   rec_q, n_rec;
	logic               is_read_q, n_is_read;
	logic               stop_q, n_stop;
	logic [7:0]         len_q, n_len;
	logic [6:0]         addr_q, n_addr;
	logic               scl_q, n_scl;
	logic               sda_q, n_sda;
	logic               astage_q, n_astage;
	logic               sample_q, n_sample;
	logic [1:0]         status_q, n_status;
	logic               over, rd, bd, sdb, fin, emit;
	logic [1:0]         fin_st;
	logic [8:0]         byte_nx;

	assign over     = (tick_q >= lim);
	assign tick_adv = over ? '0 : tick_q + 1'b1;
	assign rd       = astage_q ? bit_q[3] : (is_read_q ^ bit_q[3]);
	assign byte_nx  = {1'b0, byte_q} + 9'd1;

	always_comb begin
		n_phase = phase_q;   n_tick = tick_q;     n_bit = bit_q;     n_byte = byte_q;
		n_shift = shift_q;   n_rec = rec_q;       n_is_read = is_read_q;
		n_stop = stop_q;     n_len = len_q;       n_addr = addr_q;
		n_scl = scl_q;       n_sda = sda_q;       n_astage = astage_q;
		n_sample = sample_q; n_status = status_q;
		bd = 1'b0; sdb = 1'b0; fin = 1'b0; emit = 1'b0; fin_st = ST_OK;
		res = '0;

		unique case (phase_q)
			PH_IDLE: begin
				if (item.cmd == CMD_READ || item.cmd == CMD_WRITE) begin
					n_is_read = (item.cmd == CMD_READ);
					n_addr = item.address;
					n_len = item.length;
					n_stop = item.send_stop;
					n_scl = 1'b0;
					n_sda = 1'b0;
					n_rec = '0;
					n_tick = '0;
					n_phase = PH_CHK;
				end
			end
			PH_CHK: begin
				if (rec_q >= RECOVERY_LIMIT) begin
					n_status = ST_BUS_BUSY;
					emit = 1'b1;
				end else if (item.sda_in) begin
					n_sda = 1'b1;
					n_tick = '0;
					n_phase = PH_START;
				end else begin
					n_scl = 1'b1;
					n_tick = '0;
					n_phase = PH_RCV_LOW;
				end
			end
			PH_RCV_LOW: begin
				n_tick = tick_adv;
				if (over) begin
					n_scl = 1'b0;
					n_phase = PH_RCV_HIGH;
				end
			end
			PH_RCV_HIGH: begin
				n_tick = tick_adv;
				if (over) begin
					n_rec = rec_q + 1'b1;
					n_phase = PH_CHK;
				end
			end
			PH_START: begin
				n_tick = tick_adv;
				if (over) begin
					n_shift = {addr_q, is_read_q};
					n_astage = 1'b1;
					n_bit = '0;
					n_scl = 1'b1;
					n_tick = '0;
					n_phase = PH_BIT_A;
				end
			end
			PH_BIT_A: begin
				n_tick = tick_adv;
				if (over) begin
					if (rd)
						n_sda = 1'b0;
					else if (!bit_q[3])
						n_sda = !shift_q[7];
					else
						n_sda = (byte_nx < {1'b0, len_q});
					n_phase = PH_BIT_B;
				end
			end
			PH_BIT_B: begin
				n_tick = tick_adv;
				if (over) begin
					n_scl = 1'b0;
					n_phase = rd ? PH_BIT_R : PH_BIT_C;
				end
			end
			PH_BIT_C: begin
				n_tick = tick_adv;
				bd = over && item.scl_in;
			end
			PH_BIT_R: begin
				n_tick = '0;
				if (item.scl_in) begin
					n_sample = item.sda_in;
					n_phase = PH_BIT_D;
				end else begin
					n_phase = PH_BIT_S;
				end
			end
			PH_BIT_S: begin
				n_tick = tick_adv;
				if (over)
					n_phase = PH_BIT_R;
			end
			PH_BIT_D: begin
				n_tick = tick_adv;
				bd = over;
			end
			PH_STOP_A: begin
				n_tick = tick_adv;
				if (over) begin
					n_sda = 1'b1;
					n_phase = PH_STOP_B;
				end
			end
			PH_STOP_B: begin
				n_tick = tick_adv;
				if (over) begin
					n_scl = 1'b0;
					n_phase = PH_STOP_C;
				end
			end
			PH_STOP_C: begin
				n_tick = tick_adv;
				if (over && item.scl_in) begin
					n_sda = 1'b0;
					n_phase = PH_STOP_D;
				end
			end
			PH_STOP_D: begin
				n_tick = tick_adv;
				emit = over;
			end
			default: begin
				n_phase = PH_IDLE;
				n_tick = '0;
			end
		endcase

		if (bd) begin
			if (!bit_q[3]) begin
				n_shift = {shift_q[6:0], rd & sample_q};
				n_bit = bit_q + 1'b1;
				n_scl = 1'b1;
				n_tick = '0;
				n_phase = PH_BIT_A;
			end else if (astage_q) begin
				n_astage = 1'b0;
				n_byte = '0;
				if (sample_q) begin
					fin = 1'b1; fin_st = ST_ADDR_NACK;
				end else if (len_q == 8'd0) begin
					fin = 1'b1; fin_st = ST_OK;
				end else begin
					sdb = 1'b1;
				end
			end else if (!is_read_q && sample_q) begin
				fin = 1'b1; fin_st = ST_DATA_NACK;
			end else begin
				if (is_read_q) begin
					res.rx_data = shift_q;
					res.rx_valid = 1'b1;
				end
				n_byte = byte_nx[7:0];
				if (byte_nx[7:0] >= len_q) begin
					fin = 1'b1; fin_st = ST_OK;
				end else begin
					sdb = 1'b1;
				end
			end
		end

		if (sdb) begin
			n_bit = '0;
			if (is_read_q) begin
				n_shift = '0;
			end else begin
				n_shift = item.tx_byte;
				res.tx_taken = 1'b1;
			end
			n_scl = 1'b1;
			n_tick = '0;
			n_phase = PH_BIT_A;
		end

		if (fin) begin
			n_status = fin_st;
			n_tick = '0;
			if (stop_q) begin
				n_scl = 1'b1;
				n_phase = PH_STOP_A;
			end else begin
				emit = 1'b1;
			end
		end

		if (emit) begin
			res.done_res = 1'b1;
			res.status = n_status;
			if (n_status == ST_OK)
				res.byte_count = len_q;
			else if (n_status == ST_DATA_NACK)
				res.byte_count = n_byte;
			else
				res.byte_count = '0;
			n_phase = PH_IDLE;
			n_tick = '0;
		end

		res.scl_drive_low = n_scl;
		res.sda_drive_low = n_sda;
		res.busy_res = (n_phase != PH_IDLE);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;   tick_q <= '0;   bit_q <= '0;   byte_q <= '0;
			shift_q <= '0;        rec_q <= '0;    is_read_q <= 1'b0;
			stop_q <= 1'b0;       len_q <= '0;    addr_q <= '0;
			scl_q <= 1'b0;        sda_q <= 1'b0;  astage_q <= 1'b0;
			sample_q <= 1'b0;     status_q <= ST_OK;
		end else if (en) begin
			phase_q <= n_phase;   tick_q <= n_tick;   bit_q <= n_bit;   byte_q <= n_byte;
			shift_q <= n_shift;   rec_q <= n_rec;     is_read_q <= n_is_read;
			stop_q <= n_stop;     len_q <= n_len;     addr_q <= n_addr;
			scl_q <= n_scl;       sda_q <= n_sda;     astage_q <= n_astage;
			sample_q <= n_sample; status_q <= n_status;
		end
	end

	a_idle_tick_zero: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_IDLE |-> tick_q == '0)
		else $error("tick counter running while idle");
	a_idle_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_IDLE && !en) |=> phase_q == PH_IDLE)
		else $error("engine left idle without a tick");
	a_bit_range: assert property (@(posedge clk) disable iff (!arst_n)
		bit_q <= 4'd8)
		else $error("bit index beyond acknowledge slot");
	a_rec_range: assert property (@(posedge clk) disable iff (!arst_n)
		rec_q <= RECOVERY_LIMIT)
		else $error("recovery pulse count beyond limit");

endmodule

>>> tb/tb_top.sv
// Self-checking testbench of the I2C master engine: modeled slave bus, per-tick result prediction.
`timescale 1ns / 100ps

module tb_top;
	import i2cm_pkg::*;

	localparam logic [1:0] CMD_UNUSED = 2'd3;
	localparam int NEVER = 256;
	localparam int STRETCH_PCT = 15;
	localparam int CYCLE_LIMIT = 1000000;
	localparam int PRINT_CAP = 100;

	logic clk = 1'b0;
	logic arst_n;

	i2cm_cfg_if cfg();
	i2cm_req_if req();
	i2cm_rsp_if rsp();

	i2c_master_transaction_engine_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg),
		.req(req),
		.rsp(rsp)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// engine state as the testbench tracks it
	logic [15:0] phase_len = '0;
	logic [3:0] ph = PH_IDLE;
	logic [15:0] tick_cnt = '0;
	logic [3:0] bit_idx = '0;
	logic [7:0] byte_idx = '0;
	logic [7:0] shreg = '0;
	logic [4:0] rec_cnt = '0;
	logic rd_mode = 1'b0;
	logic stop_req = 1'b0;
	logic [7:0] len_q = '0;
	logic [6:0] addr_q = '0;
	logic scl_lo = 1'b0;
	logic sda_lo = 1'b0;
	logic addr_stage = 1'b0;
	logic smp = 1'b0;
	logic [1:0] st_q = ST_OK;
	res_t tick_res;

	res_t master_results_q[$];

	// slave and bus behavior for the running transaction
	int stuck_pulses = 0;
	bit addr_refuses = 1'b0;
	int nack_byte = NEVER;
	int drain_at = -1;

	int src_idle_pct = 0;
	int sink_idle_pct = 0;
	int ticks_sent = 0;
	int checked = 0;
	int errors = 0;
	int cycles = 0;

	function automatic bit phase_end();
		if (tick_cnt >= phase_len) begin
			tick_cnt = '0;
			return 1'b1;
		end
		tick_cnt = tick_cnt + 16'd1;
		return 1'b0;
	endfunction

	function automatic void close_transfer();
		tick_res.done_res = 1'b1;
		tick_res.status = st_q;
		if (st_q == ST_OK) tick_res.byte_count = len_q;
		else if (st_q == ST_DATA_NACK) tick_res.byte_count = byte_idx;
		ph = PH_IDLE;
		tick_cnt = '0;
	endfunction

	function automatic void end_transfer(input logic [1:0] st);
		st_q = st;
		tick_cnt = '0;
		if (stop_req) begin
			scl_lo = 1'b1;
			ph = PH_STOP_A;
		end else begin
			close_transfer();
		end
	endfunction

	function automatic void begin_bit();
		scl_lo = 1'b1;
		tick_cnt = '0;
		ph = PH_BIT_A;
	endfunction

	function automatic void begin_data_byte(input logic [7:0] tx);
		bit_idx = '0;
		if (rd_mode) begin
			shreg = '0;
		end else begin
			shreg = tx;
			tick_res.tx_taken = 1'b1;
		end
		begin_bit();
	endfunction

	function automatic bit slave_drives_bit();
		if (addr_stage) return bit_idx >= 4'd8;
		return rd_mode != (bit_idx >= 4'd8);
	endfunction

	function automatic void finish_bit(input logic [7:0] tx);
		if (bit_idx < 4'd8) begin
			shreg = {shreg[6:0], slave_drives_bit() ? smp : 1'b0};
			bit_idx = bit_idx + 4'd1;
			begin_bit();
			return;
		end
		if (addr_stage) begin
			addr_stage = 1'b0;
			byte_idx = '0;
			if (smp) end_transfer(ST_ADDR_NACK);
			else if (len_q == 8'd0) end_transfer(ST_OK);
			else begin_data_byte(tx);
			return;
		end
		if (rd_mode) begin
			tick_res.rx_data = shreg;
			tick_res.rx_valid = 1'b1;
		end else if (smp) begin
			end_transfer(ST_DATA_NACK);
			return;
		end
		byte_idx = byte_idx + 8'd1;
		if (byte_idx >= len_q) end_transfer(ST_OK);
		else begin_data_byte(tx);
	endfunction

	function automatic res_t advance_master(input req_t r);
		tick_res = '0;
		case (ph)
			PH_IDLE: begin
				if (r.cmd == CMD_READ || r.cmd == CMD_WRITE) begin
					rd_mode = (r.cmd == CMD_READ);
					addr_q = r.address;
					len_q = r.length;
					stop_req = r.send_stop;
					scl_lo = 1'b0;
					sda_lo = 1'b0;
					rec_cnt = '0;
					tick_cnt = '0;
					ph = PH_CHK;
				end
			end
			PH_CHK: begin
				if (rec_cnt >= RECOVERY_LIMIT) begin
					st_q = ST_BUS_BUSY;
					close_transfer();
				end else if (r.sda_in) begin
					sda_lo = 1'b1;
					tick_cnt = '0;
					ph = PH_START;
				end else begin
					scl_lo = 1'b1;
					tick_cnt = '0;
					ph = PH_RCV_LOW;
				end
			end
			PH_RCV_LOW: begin
				if (phase_end()) begin
					scl_lo = 1'b0;
					ph = PH_RCV_HIGH;
				end
			end
			PH_RCV_HIGH: begin
				if (phase_end()) begin
					rec_cnt = rec_cnt + 5'd1;
					ph = PH_CHK;
				end
			end
			PH_START: begin
				if (phase_end()) begin
					shreg = {addr_q, rd_mode};
					addr_stage = 1'b1;
					bit_idx = '0;
					begin_bit();
				end
			end
			PH_BIT_A: begin
				if (phase_end()) begin
					if (slave_drives_bit()) sda_lo = 1'b0;
					else if (bit_idx < 4'd8) sda_lo = !shreg[7];
					else sda_lo = ({1'b0, byte_idx} + 9'd1) < {1'b0, len_q};
					ph = PH_BIT_B;
				end
			end
			PH_BIT_B: begin
				if (phase_end()) begin
					scl_lo = 1'b0;
					ph = slave_drives_bit() ? PH_BIT_R : PH_BIT_C;
				end
			end
			PH_BIT_C: begin
				if (phase_end() && r.scl_in) finish_bit(r.tx_byte);
			end
			PH_BIT_R: begin
				tick_cnt = '0;
				if (r.scl_in) begin
					smp = r.sda_in;
					ph = PH_BIT_D;
				end else begin
					ph = PH_BIT_S;
				end
			end
			PH_BIT_S: begin
				if (phase_end()) ph = PH_BIT_R;
			end
			PH_BIT_D: begin
				if (phase_end()) finish_bit(r.tx_byte);
			end
			PH_STOP_A: begin
				if (phase_end()) begin
					sda_lo = 1'b1;
					ph = PH_STOP_B;
				end
			end
			PH_STOP_B: begin
				if (phase_end()) begin
					scl_lo = 1'b0;
					ph = PH_STOP_C;
				end
			end
			PH_STOP_C: begin
				if (phase_end() && r.scl_in) begin
					sda_lo = 1'b0;
					ph = PH_STOP_D;
				end
			end
			PH_STOP_D: begin
				if (phase_end()) close_transfer();
			end
			default: begin
				ph = PH_IDLE;
				tick_cnt = '0;
			end
		endcase
		tick_res.scl_drive_low = scl_lo;
		tick_res.sda_drive_low = sda_lo;
		tick_res.busy_res = (ph != PH_IDLE);
		return tick_res;
	endfunction

	// line levels as the slave and the pull-ups would give them
	function automatic req_t make_tick(input logic [1:0] c, input logic [6:0] a,
			input logic [7:0] n, input logic s);
		req_t r;
		r.cmd = c;
		r.address = a;
		r.length = n;
		r.send_stop = s;
		r.tx_byte = $urandom_range(255);
		r.scl_in = scl_lo ? ($urandom_range(99) < 3) : ($urandom_range(99) >= STRETCH_PCT);
		if (ph == PH_CHK) r.sda_in = (rec_cnt >= stuck_pulses);
		else if (ph == PH_BIT_R && addr_stage && bit_idx >= 4'd8) r.sda_in = addr_refuses;
		else if (ph == PH_BIT_R && !rd_mode && bit_idx >= 4'd8) r.sda_in = (byte_idx == nack_byte);
		else if (ph == PH_BIT_R) r.sda_in = $urandom_range(1);
		else r.sda_in = sda_lo ? ($urandom_range(99) < 5) : ($urandom_range(99) >= 5);
		return r;
	endfunction

	function automatic logic [1:0] busy_cmd();
		int pick;
		pick = $urandom_range(99);
		if (pick < 70) return CMD_TICK;
		if (pick < 80) return CMD_UNUSED;
		return (pick < 90) ? CMD_READ : CMD_WRITE;
	endfunction

	task automatic report_mismatch(input string what, input int got, input int want);
		if (errors < PRINT_CAP)
			$display("tick %0d: %s got %0d expected %0d", checked, what, got, want);
		errors++;
	endtask

	task automatic send_tick(input req_t r);
		while ($urandom_range(99) < src_idle_pct) begin
			req.valid <= 1'b0;
			@(posedge clk);
		end
		req.valid <= 1'b1;
		req.cmd <= r.cmd;
		req.address <= r.address;
		req.length <= r.length;
		req.send_stop <= r.send_stop;
		req.tx_byte <= r.tx_byte;
		req.scl_in <= r.scl_in;
		req.sda_in <= r.sda_in;
		@(posedge clk);
		while (!req.ready) @(posedge clk);
		master_results_q.push_back(advance_master(r));
		ticks_sent++;
	endtask

	task automatic drain_results();
		req.valid <= 1'b0;
		do @(posedge clk); while (master_results_q.size() != 0);
	endtask

	task automatic set_phase_len(input logic [15:0] v);
		drain_results();
		repeat (4) @(posedge clk);
		cfg.valid <= 1'b1;
		cfg.data <= v;
		do @(posedge clk); while (!cfg.ready);
		cfg.valid <= 1'b0;
		phase_len = v;
	endtask

	task automatic send_idle_ticks(input int k);
		for (int i = 0; i < k; i++)
			send_tick(make_tick($urandom_range(1) ? CMD_TICK : CMD_UNUSED,
				$urandom_range(127), $urandom_range(255), $urandom_range(1)));
	endtask

	task automatic run_transfer(input logic [1:0] kind, input logic [6:0] a, input logic [7:0] n,
			input logic s, input int stuck, input bit refuse, input int nack_at);
		int k;
		stuck_pulses = stuck;
		addr_refuses = refuse;
		nack_byte = nack_at;
		send_tick(make_tick(kind, a, n, s));
		k = 0;
		while (ph != PH_IDLE) begin
			if (k == drain_at) drain_results();
			send_tick(make_tick(busy_cmd(), $urandom_range(127), $urandom_range(255),
				$urandom_range(1)));
			k++;
		end
		drain_at = -1;
	endtask

	task automatic random_transfer();
		int pick;
		int stuck;
		int nk;
		logic [7:0] n;
		pick = $urandom_range(99);
		if (pick < 10) n = 8'd0;
		else if (pick < 88) n = $urandom_range(4, 1);
		else n = $urandom_range(40, 5);
		nk = NEVER;
		if ($urandom_range(4) == 0 && n != 8'd0) nk = $urandom_range(n - 1);
		pick = $urandom_range(99);
		if (pick < 75) stuck = 0;
		else if (pick < 92) stuck = $urandom_range(6, 1);
		else stuck = $urandom_range(31, 19);
		if ($urandom_range(29) == 0) drain_at = $urandom_range(40);
		run_transfer($urandom_range(1) ? CMD_READ : CMD_WRITE, $urandom_range(127), n,
			$urandom_range(99) < 70, stuck, $urandom_range(9) == 0, nk);
	endtask

	task automatic test_basic_transfers();
		run_transfer(CMD_WRITE, 7'h7f, 8'd2, 1'b1, 0, 1'b0, NEVER);
		run_transfer(CMD_READ, 7'h00, 8'd3, 1'b1, 0, 1'b0, NEVER);
		run_transfer(CMD_READ, 7'h55, 8'd1, 1'b1, 0, 1'b0, NEVER);
	endtask

	task automatic test_zero_length();
		run_transfer(CMD_WRITE, 7'h2a, 8'd0, 1'b1, 0, 1'b0, NEVER);
		run_transfer(CMD_READ, 7'h15, 8'd0, 1'b0, 0, 1'b0, NEVER);
	endtask

	task automatic test_no_stop();
		run_transfer(CMD_WRITE, 7'h2a, 8'd2, 1'b0, 0, 1'b0, NEVER);
		send_idle_ticks(3);
		run_transfer(CMD_READ, 7'h3c, 8'd2, 1'b0, 0, 1'b0, NEVER);
		run_transfer(CMD_WRITE, 7'h41, 8'd1, 1'b1, 0, 1'b0, NEVER);
	endtask

	task automatic test_nacks();
		run_transfer(CMD_WRITE, 7'h10, 8'd2, 1'b1, 0, 1'b1, NEVER);
		run_transfer(CMD_READ, 7'h11, 8'd2, 1'b0, 0, 1'b1, NEVER);
		run_transfer(CMD_WRITE, 7'h12, 8'd3, 1'b1, 0, 1'b0, 0);
		run_transfer(CMD_WRITE, 7'h13, 8'd5, 1'b0, 0, 1'b0, 2);
	endtask

	task automatic test_bus_recovery();
		run_transfer(CMD_WRITE, 7'h20, 8'd1, 1'b1, 3, 1'b0, NEVER);
		run_transfer(CMD_READ, 7'h21, 8'd1, 1'b1, RECOVERY_LIMIT - 1, 1'b0, NEVER);
		run_transfer(CMD_WRITE, 7'h22, 8'd1, 1'b1, RECOVERY_LIMIT, 1'b0, NEVER);
	endtask

	task automatic test_ignored_commands();
		send_idle_ticks(8);
		drain_at = 5;
		run_transfer(CMD_WRITE, 7'h33, 8'd2, 1'b1, 0, 1'b0, NEVER);
		send_idle_ticks(4);
	endtask

	task automatic test_long_transfers();
		run_transfer(CMD_READ, 7'h6e, 8'd255, 1'b1, 0, 1'b0, NEVER);
		run_transfer(CMD_WRITE, 7'h6f, 8'd255, 1'b1, 0, 1'b0, 254);
	endtask

	task automatic test_phase_length();
		set_phase_len(16'd300);
		run_transfer(CMD_WRITE, 7'h5a, 8'd0, 1'b1, 0, 1'b0, NEVER);
		set_phase_len(16'hffff);
		send_idle_ticks(6);
		set_phase_len(16'd1);
		run_transfer(CMD_READ, 7'h5b, 8'd2, 1'b1, 2, 1'b0, NEVER);
		set_phase_len(16'd0);
	endtask

	task automatic test_random_traffic(input int src_pct, input int sink_pct, input int budget);
		int start;
		src_idle_pct = src_pct;
		sink_idle_pct = sink_pct;
		start = ticks_sent;
		set_phase_len($urandom_range(3));
		while (ticks_sent - start < budget) begin
			if ($urandom_range(9) == 0) set_phase_len($urandom_range(3));
			send_idle_ticks($urandom_range(3));
			random_transfer();
		end
	endtask

	always @(posedge clk) begin
		res_t want;
		if (rsp.valid && rsp.ready) begin
			if (master_results_q.size() == 0) begin
				report_mismatch("result with no tick pending", 1, 0);
			end else begin
				want = master_results_q.pop_front();
				if (rsp.scl_drive_low !== want.scl_drive_low)
					report_mismatch("scl_drive_low", rsp.scl_drive_low, want.scl_drive_low);
				if (rsp.sda_drive_low !== want.sda_drive_low)
					report_mismatch("sda_drive_low", rsp.sda_drive_low, want.sda_drive_low);
				if (rsp.rx_data !== want.rx_data)
					report_mismatch("rx_data", rsp.rx_data, want.rx_data);
				if (rsp.rx_valid !== want.rx_valid)
					report_mismatch("rx_valid", rsp.rx_valid, want.rx_valid);
				if (rsp.tx_taken !== want.tx_taken)
					report_mismatch("tx_taken", rsp.tx_taken, want.tx_taken);
				if (rsp.busy_res !== want.busy_res)
					report_mismatch("busy_res", rsp.busy_res, want.busy_res);
				if (rsp.done_res !== want.done_res)
					report_mismatch("done_res", rsp.done_res, want.done_res);
				if (rsp.status !== want.status)
					report_mismatch("status", rsp.status, want.status);
				if (rsp.byte_count !== want.byte_count)
					report_mismatch("byte_count", rsp.byte_count, want.byte_count);
			end
			checked++;
		end
		rsp.ready <= ($urandom_range(99) >= sink_idle_pct);
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		cfg.valid = 1'b0;
		cfg.data = '0;
		req.valid = 1'b0;
		req.cmd = CMD_TICK;
		req.address = '0;
		req.length = '0;
		req.send_stop = 1'b0;
		req.tx_byte = '0;
		req.scl_in = 1'b1;
		req.sda_in = 1'b1;
		rsp.ready = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		src_idle_pct = 20;
		sink_idle_pct = 45;
		set_phase_len(16'd0);
		test_basic_transfers();
		test_zero_length();
		test_no_stop();
		test_nacks();
		test_bus_recovery();
		test_ignored_commands();
		test_long_transfers();
		test_phase_length();

		test_random_traffic(20, 45, 400);
		test_random_traffic(45, 20, 400);
		test_random_traffic(0, 0, 400);

		drain_results();
		repeat (6) @(posedge clk);
		if (errors == 0) $display("ALL CHECKS PASSED");
		else $display("CHECKS FAILED");
		$finish;
	end

endmodule
